/* design/group_telegram_queue_framer_assert.svh */
// Assertion macros shared by the framer. Each one samples on the rising edge
// of clk and is switched off while arst_n is low.
`ifndef GROUP_TELEGRAM_QUEUE_FRAMER_ASSERT_SVH
`define GROUP_TELEGRAM_QUEUE_FRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTQF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTQF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/gtqf_pkg.sv */
`default_nettype none
package gtqf_pkg;

	localparam int SLOTS       = 16;
	localparam int MAX_PAYLOAD = 18;

	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int FILL_W    = $clog2(MAX_PAYLOAD + 1);
	localparam int PAY_DEPTH = SLOTS * MAX_PAYLOAD;
	localparam int PAY_AW    = $clog2(PAY_DEPTH);
	localparam int HDR_BYTES = 6;
	localparam int LEN_BIAS  = 4;
	localparam int IDX_W     = $clog2(MAX_PAYLOAD + HDR_BYTES);
	localparam int DEST_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int STAT_W    = 3;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic [STAT_W-1:0] ST_FRAME    = 3'd0;
	localparam logic [STAT_W-1:0] ST_ACCEPT   = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd4;

	localparam logic KIND_ENQ  = 1'b0;
	localparam logic KIND_SEND = 1'b1;

	localparam logic [BYTE_W-1:0] HDR_ZERO  = 8'h00;
	localparam logic [BYTE_W-1:0] HDR_PROTO = 8'h27;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [FILL_W-1:0] fill_t;

	// One entry of the command queue: a single status beat or a whole frame.
	typedef struct packed {
		logic              is_frame;
		logic [STAT_W-1:0] status;
		slot_t             slot;
	} cmd_t;

	// Store writes from the front to the stores held by the back.
	typedef struct packed {
		logic              pay_we;
		logic [PAY_AW-1:0] pay_addr;
		logic [BYTE_W-1:0] pay_data;
		logic              dest_we;
		logic [DEST_W-1:0] dest;
		logic              len_we;
		fill_t             len;
		slot_t             slot;
	} wr_t;

	function automatic slot_t slot_next(input slot_t s);
		return (s == SLOT_W'(SLOTS - 1)) ? '0 : slot_t'(s + SLOT_W'(1));
	endfunction

	// Distance from b forward to a around the ring.
	function automatic logic [SLOT_W:0] slot_dist(input slot_t a, input slot_t b);
		logic [SLOT_W:0] wa;
		logic [SLOT_W:0] wb;
		wa = {1'b0, a};
		wb = {1'b0, b};
		return (a >= b) ? (wa - wb) : (wa + (SLOT_W + 1)'(SLOTS) - wb);
	endfunction

endpackage
`default_nettype wire

/* design/gtqf_front.sv */
`default_nettype none
module gtqf_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        kind,
	input  wire logic [gtqf_pkg::DEST_W-1:0] dest_group,
	input  wire logic [gtqf_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                        last_byte,
	input  wire logic                        rel,
	output gtqf_pkg::cmd_t                   q_wdata,
	output logic                             q_push,
	input  wire logic                        q_full,
	output gtqf_pkg::wr_t                    wr
);

	gtqf_pkg::slot_t ws_q, rs_q, done_q;
	gtqf_pkg::fill_t fill_q;
	logic            disc_q;

	gtqf_pkg::slot_t ws_n, rs_n;
	gtqf_pkg::fill_t fill_n;
	logic            disc_n;
	logic [gtqf_pkg::SLOT_W:0] pend, wdist;
	logic            alias_hit, accept, ring_full;
	gtqf_pkg::cmd_t  cmd;
	gtqf_pkg::wr_t   wr_c;

	// Slots from done_q up to rs_q are still being streamed by the back; the
	// telegram under assembly must not land in one of them.
	assign pend      = gtqf_pkg::slot_dist(rs_q, done_q);
	assign wdist     = gtqf_pkg::slot_dist(ws_q, done_q);
	assign alias_hit = (pend != '0) && (wdist < pend);
	assign in_stall  = q_full || ((kind == gtqf_pkg::KIND_ENQ) && alias_hit);
	assign accept    = in_valid && !in_stall;
	assign ring_full = (gtqf_pkg::slot_next(ws_q) == rs_q);

	always_comb begin
		ws_n          = ws_q;
		rs_n          = rs_q;
		fill_n        = fill_q;
		disc_n        = disc_q;
		cmd.is_frame  = 1'b0;
		cmd.status    = gtqf_pkg::ST_ACCEPT;
		cmd.slot      = rs_q;
		wr_c.pay_we   = 1'b0;
		wr_c.pay_addr = gtqf_pkg::PAY_AW'(gtqf_pkg::PAY_AW'(ws_q)
			* gtqf_pkg::PAY_AW'(gtqf_pkg::MAX_PAYLOAD) + gtqf_pkg::PAY_AW'(fill_q));
		wr_c.pay_data = data_byte;
		wr_c.dest_we  = 1'b0;
		wr_c.dest     = dest_group;
		wr_c.len_we   = 1'b0;
		wr_c.len      = gtqf_pkg::fill_t'(fill_q + 1'b1);
		wr_c.slot     = ws_q;
		if (kind == gtqf_pkg::KIND_SEND) begin
			if (rs_q == ws_q) begin
				cmd.status = gtqf_pkg::ST_EMPTY;
			end else begin
				cmd.is_frame = 1'b1;
				cmd.status   = gtqf_pkg::ST_FRAME;
				rs_n         = gtqf_pkg::slot_next(rs_q);
			end
		end else if (disc_q) begin
			cmd.status = (fill_q == '0) ? gtqf_pkg::ST_FULL : gtqf_pkg::ST_TOO_LONG;
			if (last_byte) begin
				disc_n = 1'b0;
				fill_n = '0;
			end
		end else if ((fill_q == '0) && ring_full) begin
			cmd.status = gtqf_pkg::ST_FULL;
			if (!last_byte) begin
				disc_n = 1'b1;
			end
		end else if (fill_q >= gtqf_pkg::FILL_W'(gtqf_pkg::MAX_PAYLOAD)) begin
			cmd.status = gtqf_pkg::ST_TOO_LONG;
			if (last_byte) begin
				fill_n = '0;
			end else begin
				disc_n = 1'b1;
			end
		end else begin
			wr_c.pay_we  = 1'b1;
			wr_c.dest_we = (fill_q == '0);
			fill_n       = gtqf_pkg::fill_t'(fill_q + 1'b1);
			if (last_byte) begin
				wr_c.len_we = 1'b1;
				ws_n        = gtqf_pkg::slot_next(ws_q);
				fill_n      = '0;
			end
		end
	end

	always_comb begin
		wr         = wr_c;
		wr.pay_we  = wr_c.pay_we && accept;
		wr.dest_we = wr_c.dest_we && accept;
		wr.len_we  = wr_c.len_we && accept;
	end

	assign q_wdata = cmd;
	assign q_push  = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= '0;
			rs_q   <= '0;
			done_q <= '0;
			fill_q <= '0;
			disc_q <= 1'b0;
		end else begin
			if (accept) begin
				ws_q   <= ws_n;
				rs_q   <= rs_n;
				fill_q <= fill_n;
				disc_q <= disc_n;
			end
			if (rel) begin
				done_q <= gtqf_pkg::slot_next(done_q);
			end
		end
	end

endmodule
`default_nettype wire

/* design/gtqf_cmdq.sv */
`default_nettype none
module gtqf_cmdq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire gtqf_pkg::cmd_t wdata,
	output logic                full,
	input  wire logic           pop,
	output logic                rvalid,
	output gtqf_pkg::cmd_t      rdata
);

	gtqf_pkg::cmd_t                 entry_q [gtqf_pkg::CMDQ_DEPTH];
	logic [gtqf_pkg::CMDQ_AW-1:0]   wp_q, rp_q;
	logic [gtqf_pkg::CMDQ_AW:0]     cnt_q;

	assign full   = (cnt_q == (gtqf_pkg::CMDQ_AW + 1)'(gtqf_pkg::CMDQ_DEPTH));
	assign rvalid = (cnt_q != '0);
	assign rdata  = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/gtqf_back.sv */
`default_nettype none
module gtqf_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gtqf_pkg::wr_t                wr,
	input  wire logic                         q_valid,
	input  wire gtqf_pkg::cmd_t               q_cmd,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [gtqf_pkg::STAT_W-1:0]       status,
	output logic [gtqf_pkg::BYTE_W-1:0]       frame_byte,
	output logic                              frame_end,
	output logic                              rel
);

	localparam logic BK_IDLE  = 1'b0;
	localparam logic BK_FRAME = 1'b1;

	logic [gtqf_pkg::BYTE_W-1:0] pay_mem [gtqf_pkg::PAY_DEPTH];
	logic [gtqf_pkg::DEST_W-1:0] dest_mem [gtqf_pkg::SLOTS];
	gtqf_pkg::fill_t             len_mem [gtqf_pkg::SLOTS];

	logic                        state_q;
	logic [gtqf_pkg::IDX_W-1:0]  idx_q;
	gtqf_pkg::slot_t             slot_q;
	logic [gtqf_pkg::DEST_W-1:0] dest_q;
	gtqf_pkg::fill_t             len_q;
	logic [gtqf_pkg::BYTE_W-1:0] rdata_q;
	logic                        out_valid_q;
	logic [gtqf_pkg::STAT_W-1:0] status_q;
	logic [gtqf_pkg::BYTE_W-1:0] byte_q;
	logic                        end_q;

	logic                        advance, start_frame, load_single, load_frame, is_last;
	logic                        rd_en;
	logic [gtqf_pkg::IDX_W-1:0]  last_idx, rd_p;
	logic [gtqf_pkg::PAY_AW-1:0] rd_addr;
	logic [15:0]                 total;
	logic [gtqf_pkg::BYTE_W-1:0] hdr_byte;

	assign advance     = !out_valid_q || !out_stall;
	assign q_pop       = q_valid && (state_q == BK_IDLE) && (q_cmd.is_frame || advance);
	assign start_frame = q_pop && q_cmd.is_frame;
	assign load_single = q_pop && !q_cmd.is_frame;
	assign load_frame  = (state_q == BK_FRAME) && advance;

	assign last_idx = gtqf_pkg::IDX_W'(gtqf_pkg::HDR_BYTES - 1) + gtqf_pkg::IDX_W'(len_q);
	assign is_last  = (idx_q == last_idx);
	assign rel      = load_frame && is_last;
	assign total    = 16'(gtqf_pkg::LEN_BIAS) + 16'(len_q);

	// The payload byte for the next beat is fetched while the current one
	// is loaded, so the registered read data is ready one beat later.
	assign rd_p    = gtqf_pkg::IDX_W'(idx_q - gtqf_pkg::IDX_W'(gtqf_pkg::HDR_BYTES - 1));
	assign rd_en   = load_frame && !is_last
		&& (idx_q >= gtqf_pkg::IDX_W'(gtqf_pkg::HDR_BYTES - 1));
	assign rd_addr = gtqf_pkg::PAY_AW'(gtqf_pkg::PAY_AW'(slot_q)
		* gtqf_pkg::PAY_AW'(gtqf_pkg::MAX_PAYLOAD) + gtqf_pkg::PAY_AW'(rd_p));

	always_comb begin
		case (idx_q)
			gtqf_pkg::IDX_W'(0): hdr_byte = total[15:8];
			gtqf_pkg::IDX_W'(1): hdr_byte = total[7:0];
			gtqf_pkg::IDX_W'(2): hdr_byte = gtqf_pkg::HDR_ZERO;
			gtqf_pkg::IDX_W'(3): hdr_byte = gtqf_pkg::HDR_PROTO;
			gtqf_pkg::IDX_W'(4): hdr_byte = dest_q[15:8];
			gtqf_pkg::IDX_W'(5): hdr_byte = dest_q[7:0];
			default:             hdr_byte = rdata_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr.pay_we) begin
			pay_mem[wr.pay_addr] <= wr.pay_data;
		end
		if (wr.dest_we) begin
			dest_mem[wr.slot] <= wr.dest;
		end
		if (wr.len_we) begin
			len_mem[wr.slot] <= wr.len;
		end
		if (rd_en) begin
			rdata_q <= pay_mem[rd_addr];
		end
		if (start_frame) begin
			slot_q <= q_cmd.slot;
			dest_q <= dest_mem[q_cmd.slot];
			len_q  <= len_mem[q_cmd.slot];
		end
		if (load_single) begin
			status_q <= q_cmd.status;
			byte_q   <= '0;
			end_q    <= 1'b1;
		end else if (load_frame) begin
			status_q <= gtqf_pkg::ST_FRAME;
			byte_q   <= hdr_byte;
			end_q    <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_single || load_frame) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (start_frame) begin
						state_q <= BK_FRAME;
						idx_q   <= '0;
					end
				end
				BK_FRAME: begin
					if (load_frame) begin
						if (is_last) begin
							state_q <= BK_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame_byte = byte_q;
	assign frame_end  = end_q;

endmodule
`default_nettype wire

/* design/group_telegram_queue_framer.sv */
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  kind, dest_group, data_byte, last_byte
// out       source     out_valid / out_stall status, frame_byte, frame_end
//
// An enqueue byte or an empty-queue send gives one status beat, passing through the command
// queue and the output register. A send of a stored telegram gives 6 + length beats,
// one a cycle while out_stall is low, after the pop that loads its destination and length.
// Reset clears all pointers and counters at once; the stores need no clearing.
// A full command queue, or a telegram that would land in a slot still being sent,
// stalls the input; out_stall holds the output register and the back part.
`default_nettype none
`include "group_telegram_queue_framer_assert.svh"
module group_telegram_queue_framer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         kind,
	input  wire logic [gtqf_pkg::DEST_W-1:0]  dest_group,
	input  wire logic [gtqf_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                         last_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [gtqf_pkg::STAT_W-1:0]       status,
	output logic [gtqf_pkg::BYTE_W-1:0]       frame_byte,
	output logic                              frame_end
);

	gtqf_pkg::cmd_t q_wdata, q_rdata;
	gtqf_pkg::wr_t  wr;
	logic           q_push, q_full, q_pop, q_valid, rel;

	gtqf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.dest_group (dest_group),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.rel        (rel),
		.q_wdata    (q_wdata),
		.q_push     (q_push),
		.q_full     (q_full),
		.wr         (wr)
	);

	gtqf_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	gtqf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.q_valid    (q_valid),
		.q_cmd      (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.rel        (rel)
	);

	// A status beat is always the only beat of its item.
	`GTQF_ASSERT_NOW(a_status_ends, out_valid && (status != gtqf_pkg::ST_FRAME), frame_end, "status beat without end mark")
	`GTQF_ASSERT_NOW(a_status_zero, out_valid && (status != gtqf_pkg::ST_FRAME), frame_byte == '0, "status beat with nonzero byte")
	// Releasing a slot coincides with loading the closing frame beat.
	`GTQF_ASSERT_NEXT(a_release_end, rel, out_valid && frame_end && (status == gtqf_pkg::ST_FRAME), "slot released without closing beat")

endmodule
`default_nettype wire
